@@ rtl/shll_pkg.sv @@
// Package for the seeded histogram log-likelihood block.
// Holds widths, register indexes, the request struct and the sequencer states.
package shll_pkg;
    localparam int MaxBins = 32;
    localparam int BinBits = 5;
    localparam int CountBits = 21;
    localparam int QueueDepth = 4;
    localparam int QueuePtrBits = 2;
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
    localparam logic [17:0] EmptyEnergy = 18'd256000;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;

    localparam logic [0:0] RegNumBins = 1'd0;
    localparam logic [0:0] RegSeedThreshold = 1'd1;

    typedef struct packed {
        logic               emit;
        logic [BinBits-1:0] bin;
        logic [BinBits-1:0] last_bin;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOG_TOTAL,
        ST_LOG_COUNT,
        ST_SCALE,
        ST_ROUND
    } state_t;
endpackage

@@ rtl/shll_front.sv @@
// Front end: qualifies pixel requests and computes their bin.
// Depends on shll_pkg.
module shll_front
(
    input  logic                       start,
    input  logic                       op,
    input  logic [16:0]                pixel_value,
    input  logic [15:0]                seed_level,
    input  logic [5:0]                 num_bins_q,
    input  logic [15:0]                seed_threshold_q,
    output logic                       push,
    output shll_pkg::req_t             req
);
    logic [5:0]  nb;
    logic [22:0] prod;
    logic [6:0]  raw;

    always_comb
    begin
        nb = num_bins_q;
        if (nb == 6'd0)
        begin
            nb = 6'd1;
        end
        else if (nb > 6'd32)
        begin
            nb = 6'd32;
        end
        prod = {6'd0, pixel_value} * {17'd0, nb};
        raw = {1'b0, prod[21:16]};
        req.emit = op;
        req.last_bin = shll_pkg::BinBits'(nb - 6'd1);
        if (pixel_value[16] || raw >= {1'b0, nb})
        begin
            req.bin = shll_pkg::BinBits'(nb - 6'd1);
        end
        else
        begin
            req.bin = raw[shll_pkg::BinBits-1:0];
        end
        push = start && (op || (seed_level > seed_threshold_q));
    end
endmodule

@@ rtl/shll_queue.sv @@
// Short request queue between front end and back end.
// Depends on shll_pkg.
module shll_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  shll_pkg::req_t push_req,
    input  logic           pop,
    output logic           empty,
    output logic           full,
    output shll_pkg::req_t head
);
    shll_pkg::req_t mem_reg [shll_pkg::QueueDepth];
    logic [shll_pkg::QueuePtrBits-1:0] wr_reg;
    logic [shll_pkg::QueuePtrBits-1:0] rd_reg;
    logic [shll_pkg::QueuePtrBits:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == (shll_pkg::QueuePtrBits+1)'(shll_pkg::QueueDepth));
    assign head = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end
endmodule

@@ rtl/shll_log2.sv @@
// Iterative log2 in Q.16 by repeated squaring, one square per cycle.
// Depends on shll_pkg.
module shll_log2
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [shll_pkg::CountBits-1:0] x,
    output logic        done,
    output logic [20:0] result
);
    logic [32:0] m_reg, m_next;
    logic [20:0] r_reg, r_next;
    logic [4:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  p;
    logic [65:0] sq;
    logic [34:0] sqs;

    assign done = done_reg;
    assign result = r_reg;

    always_comb
    begin
        p = '0;
        for (int i = 0; i < shll_pkg::CountBits; i++)
        begin
            if (x[i])
            begin
                p = 5'(i);
            end
        end
        sq = m_reg * m_reg;
        sqs = sq[65:31];
        m_next = m_reg;
        r_next = r_reg;
        step_next = step_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            m_next = 33'({12'd0, x} << (5'd31 - p));
            r_next = {p, 16'd0};
            step_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (sqs[32])
            begin
                m_next = sqs[33:1];
                r_next = r_reg | (21'd1 << (4'd15 - step_reg[3:0]));
            end
            else
            begin
                m_next = sqs[32:0];
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd15)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        r_reg <= r_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end
endmodule

@@ rtl/shll_back.sv @@
// Back end: updates the count memory and streams energies on emit.
// Depends on shll_pkg and shll_log2.
module shll_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  shll_pkg::req_t head,
    output logic           pop,
    output logic           busy_back,
    output logic           result_valid,
    output logic [4:0]     bin_index,
    output logic [17:0]    energy,
    output logic           last
);
    logic [shll_pkg::CountBits-1:0] cnt_mem [shll_pkg::MaxBins];
    logic [shll_pkg::MaxBins-1:0]   vld_reg, vld_next;
    logic [shll_pkg::CountBits-1:0] total_reg, total_next;
    logic [shll_pkg::CountBits-1:0] rd_data_reg;
    logic                           rd_vld_reg;
    logic [shll_pkg::BinBits-1:0]   rd_addr;
    logic                           inc_v_reg, inc_v_next;
    logic [shll_pkg::BinBits-1:0]   inc_bin_reg, inc_bin_next;
    logic                           fwd_v_reg;
    logic [shll_pkg::CountBits-1:0] fwd_data_reg;
    shll_pkg::state_t state_reg, state_next;
    logic [shll_pkg::BinBits-1:0] idx_reg, idx_next;
    logic [shll_pkg::BinBits-1:0] lastb_reg, lastb_next;
    logic [20:0] lt_reg, lt_next;
    logic [52:0] prod_reg, prod_next;
    logic [20:0] d;
    logic        wr_en;
    logic [shll_pkg::BinBits-1:0] wr_addr;
    logic [shll_pkg::CountBits-1:0] wr_data;
    logic [shll_pkg::CountBits-1:0] cur;
    logic        lg_go, lg_done;
    logic [shll_pkg::CountBits-1:0] lg_x;
    logic [20:0] lg_r;
    logic        res_v_reg, res_v_next;
    logic [4:0]  res_i_reg, res_i_next;
    logic [17:0] res_e_reg, res_e_next;
    logic        res_l_reg, res_l_next;

    shll_log2 u_log2 (.clk(clk), .rst_n(rst_n), .go(lg_go), .x(lg_x),
        .done(lg_done), .result(lg_r));

    assign result_valid = res_v_reg;
    assign bin_index = res_i_reg;
    assign energy = res_e_reg;
    assign last = res_l_reg;
    assign busy_back = (state_reg != shll_pkg::ST_IDLE);

    always_comb
    begin
        cur = fwd_v_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0);
        rd_addr = (state_reg == shll_pkg::ST_IDLE) ? head.bin : idx_reg;
        state_next = state_reg;
        idx_next = idx_reg;
        lastb_next = lastb_reg;
        lt_next = lt_reg;
        prod_next = prod_reg;
        total_next = total_reg;
        vld_next = vld_reg;
        inc_v_next = 1'b0;
        inc_bin_next = inc_bin_reg;
        pop = 1'b0;
        wr_en = inc_v_reg;
        wr_addr = inc_bin_reg;
        wr_data = (cur != shll_pkg::CountMax) ? cur + 1'b1 : cur;
        lg_go = 1'b0;
        lg_x = total_reg;
        res_v_next = 1'b0;
        res_i_next = res_i_reg;
        res_e_next = res_e_reg;
        res_l_next = 1'b0;
        d = (lt_reg > lg_r) ? (lt_reg - lg_r) : '0;
        case (state_reg)
            shll_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.emit)
                    begin
                        idx_next = '0;
                        lastb_next = head.last_bin;
                        state_next = shll_pkg::ST_READ;
                    end
                    else
                    begin
                        inc_v_next = 1'b1;
                        inc_bin_next = head.bin;
                        vld_next[head.bin] = 1'b1;
                        if (total_reg != shll_pkg::CountMax)
                        begin
                            total_next = total_reg + 1'b1;
                        end
                    end
                end
            end
            shll_pkg::ST_READ:
            begin
                lg_go = 1'b1;
                lg_x = total_reg;
                state_next = shll_pkg::ST_LOG_TOTAL;
            end
            shll_pkg::ST_LOG_TOTAL:
            begin
                if (lg_done)
                begin
                    lt_next = lg_r;
                    lg_go = 1'b1;
                    lg_x = rd_vld_reg ? rd_data_reg : '0;
                    state_next = shll_pkg::ST_LOG_COUNT;
                end
            end
            shll_pkg::ST_LOG_COUNT:
            begin
                if (lg_done)
                begin
                    prod_next = {32'd0, d} * {21'd0, shll_pkg::Ln2Q32};
                    state_next = shll_pkg::ST_SCALE;
                end
            end
            shll_pkg::ST_SCALE:
            begin
                prod_next = prod_reg + (53'd1 << 39);
                state_next = shll_pkg::ST_ROUND;
            end
            shll_pkg::ST_ROUND:
            begin
                res_v_next = 1'b1;
                res_i_next = idx_reg;
                res_l_next = (idx_reg == lastb_reg);
                if (!rd_vld_reg || rd_data_reg == '0 || total_reg == '0)
                begin
                    res_e_next = shll_pkg::EmptyEnergy;
                end
                else
                begin
                    res_e_next = {5'd0, prod_reg[52:40]};
                end
                if (idx_reg == lastb_reg)
                begin
                    vld_next = '0;
                    total_next = '0;
                    state_next = shll_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = shll_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = shll_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cnt_mem[rd_addr];
        fwd_data_reg <= wr_data;
        inc_bin_reg <= inc_bin_next;
        lt_reg <= lt_next;
        prod_reg <= prod_next;
        idx_reg <= idx_next;
        lastb_reg <= lastb_next;
        res_i_reg <= res_i_next;
        res_e_reg <= res_e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shll_pkg::ST_IDLE;
            vld_reg <= '0;
            total_reg <= '0;
            rd_vld_reg <= 1'b0;
            inc_v_reg <= 1'b0;
            fwd_v_reg <= 1'b0;
            res_v_reg <= 1'b0;
            res_l_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            total_reg <= total_next;
            rd_vld_reg <= vld_reg[rd_addr];
            inc_v_reg <= inc_v_next;
            fwd_v_reg <= wr_en && (wr_addr == rd_addr);
            res_v_reg <= res_v_next;
            res_l_reg <= res_l_next;
        end
    end
endmodule

@@ rtl/seeded_histogram_log_likelihood.sv @@
// Seeded histogram with negative log likelihood readout.
// Pixel requests: one per cycle unless busy; no result; queued, then counted.
// Emit request: one result per bin in use, in order; last flags the final one.
// busy rises while an emit runs or the queue is full; results cannot be stalled.
// Reset clears counts (valid bits), total, queue and restores register defaults.
// Depends on shll_pkg, shll_front, shll_queue, shll_back.
module seeded_histogram_log_likelihood
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [16:0] pixel_value,
    input  logic [15:0] seed_level,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [4:0]  bin_index,
    output logic [17:0] energy,
    output logic        last
);
    logic [5:0]  num_bins_reg;
    logic [15:0] seed_threshold_reg;
    logic        push, pop, q_empty, q_full, busy_back, emit_pend_reg;
    shll_pkg::req_t req, head;

    assign busy = q_full || emit_pend_reg || busy_back;

    shll_front u_front (.start(start && !busy), .op(op), .pixel_value(pixel_value),
        .seed_level(seed_level), .num_bins_q(num_bins_reg),
        .seed_threshold_q(seed_threshold_reg), .push(push), .req(req));

    shll_queue u_queue (.clk(clk), .rst_n(rst_n), .push(push), .push_req(req),
        .pop(pop), .empty(q_empty), .full(q_full), .head(head));

    shll_back u_back (.clk(clk), .rst_n(rst_n), .empty(q_empty), .head(head),
        .pop(pop), .busy_back(busy_back), .result_valid(result_valid),
        .bin_index(bin_index), .energy(energy), .last(last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg <= 6'd20;
            seed_threshold_reg <= 16'd6554;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == shll_pkg::RegNumBins)
            begin
                num_bins_reg <= cfg_data[5:0];
            end
            if (cfg_we && cfg_index == shll_pkg::RegSeedThreshold)
            begin
                seed_threshold_reg <= cfg_data;
            end
            if (push && req.emit)
            begin
                emit_pend_reg <= 1'b1;
            end
            else if (pop && head.emit)
            begin
                emit_pend_reg <= 1'b0;
            end
        end
    end

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid) else $error("last without result");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push) else $error("push into full queue");
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)) else $error("result while idle");
endmodule

@@ dv/seeded_histogram_log_likelihood_test.sv @@
// Testbench for the seeded histogram log-likelihood block.
// Drives pixel and emit requests, predicts each bin energy and checks every result.
// Depends on shll_pkg and the seeded_histogram_log_likelihood RTL.
`timescale 1ns / 1ps

module seeded_histogram_log_likelihood_test;
    localparam logic OpPixel = 1'b0;
    localparam logic OpEmit = 1'b1;
    localparam int SettleCycles = 80;

    typedef struct {
        logic [4:0]  bin;
        logic [17:0] energy;
        logic        last;
    } bin_energy_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        op = 1'b0;
    logic [16:0] pixel_value = '0;
    logic [15:0] seed_level = '0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        result_valid;
    logic [4:0]  bin_index;
    logic [17:0] energy;
    logic        last;

    logic [shll_pkg::CountBits-1:0] hist_counts [shll_pkg::MaxBins];
    logic [shll_pkg::CountBits-1:0] hist_total;
    logic [5:0]           num_bins_reg;
    logic [15:0]          threshold_reg;
    bin_energy_t          pending_energies [$];
    int                   mismatches = 0;

    seeded_histogram_log_likelihood DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] log2_q16(logic [31:0] x);
        logic [63:0] m;
        logic [63:0] r;
        int p;
        p = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if (x[b] && p == 0)
            begin
                p = b;
                break;
            end
        end
        m = 64'(x) << (31 - p);
        r = 64'(p) << 16;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                r[15 - i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [17:0] bin_energy(logic [shll_pkg::CountBits-1:0] count,
                                               logic [shll_pkg::CountBits-1:0] total);
        logic [63:0] lt;
        logic [63:0] lc;
        logic [63:0] d;
        if (count == 0 || total == 0)
            return shll_pkg::EmptyEnergy;
        lt = log2_q16(32'(total));
        lc = log2_q16(32'(count));
        d = (lt > lc) ? lt - lc : 64'd0;
        return 18'((d * 64'(shll_pkg::Ln2Q32) + (64'd1 << 39)) >> 40);
    endfunction

    function automatic int bins_in_use();
        int nb;
        nb = num_bins_reg;
        if (nb == 0)
            nb = 1;
        if (nb > shll_pkg::MaxBins)
            nb = shll_pkg::MaxBins;
        return nb;
    endfunction

    function automatic void predict_request(logic o, logic [16:0] pix, logic [15:0] seed);
        int nb;
        int b;
        bin_energy_t e;
        nb = bins_in_use();
        if (o == OpPixel)
        begin
            if (seed <= threshold_reg)
                return;
            if (pix >= 17'd65536)
                b = nb - 1;
            else
                b = int'((64'(pix) * 64'(nb)) >> 16);
            if (b >= nb)
                b = nb - 1;
            if (hist_counts[b] != shll_pkg::CountMax)
                hist_counts[b]++;
            if (hist_total != shll_pkg::CountMax)
                hist_total++;
            return;
        end
        for (int i = 0; i < nb; i++)
        begin
            e.bin = 5'(i);
            e.energy = bin_energy(hist_counts[i], hist_total);
            e.last = (i == nb - 1);
            pending_energies.push_back(e);
        end
        foreach (hist_counts[i])
            hist_counts[i] = '0;
        hist_total = '0;
    endfunction

    always @(negedge clk)
    begin
        bin_energy_t e;
        if (rst_n && result_valid)
        begin
            if (pending_energies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bin %0d energy %0d last %0d",
                             bin_index, energy, last);
            end
            else
            begin
                e = pending_energies.pop_front();
                if (e.bin !== bin_index || e.energy !== energy || e.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp bin %0d e %0d l %0d, got %0d e %0d l %0d",
                                 e.bin, e.energy, e.last, bin_index, energy, last);
                end
            end
        end
    end

    task automatic send_request(logic o, logic [16:0] pix, logic [15:0] seed, int gap);
        logic was_busy;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        pixel_value <= pix;
        seed_level <= seed;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        predict_request(o, pix, seed);
    endtask

    task automatic send_random(logic o, logic [16:0] pix, logic [15:0] seed);
        send_request(o, pix, seed, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_energies.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == shll_pkg::RegNumBins)
            num_bins_reg = value[5:0];
        else
            threshold_reg = value;
        @(posedge clk);
    endtask

    task automatic test_defaults();
        send_request(OpEmit, '0, '0, 0);
        send_request(OpPixel, 17'd0, 16'd65535, 0);
        send_request(OpPixel, 17'd65535, 16'd6555, 0);
        send_request(OpPixel, 17'd65536, 16'd40000, 1);
        send_request(OpPixel, 17'h1FFFF, 16'd40000, 0);
        send_request(OpPixel, 17'd30000, 16'd6554, 0);
        send_request(OpPixel, 17'd30000, 16'd0, 2);
        send_request(OpPixel, 17'd32768, 16'd7000, 0);
        send_request(OpEmit, 17'h1FFFF, 16'hFFFF, 0);
    endtask

    task automatic test_bin_extremes();
        write_reg(shll_pkg::RegSeedThreshold, 16'd0);
        write_reg(shll_pkg::RegNumBins, 16'd0);
        send_request(OpPixel, 17'd100, 16'd1, 0);
        send_request(OpPixel, 17'd65536, 16'd1, 0);
        send_request(OpEmit, '0, '0, 0);
        write_reg(shll_pkg::RegNumBins, 16'd32);
        send_request(OpPixel, 17'd0, 16'd1, 0);
        send_request(OpPixel, 17'd2047, 16'd1, 0);
        send_request(OpPixel, 17'd65535, 16'd1, 0);
        send_request(OpPixel, 17'd40000, 16'd1, 0);
        write_reg(shll_pkg::RegNumBins, 16'd4);
        send_request(OpPixel, 17'd20000, 16'd1, 0);
        send_request(OpEmit, '0, '0, 0);
        write_reg(shll_pkg::RegNumBins, 16'hFFFF);
        send_request(OpPixel, 17'd65536, 16'd1, 0);
        send_request(OpEmit, '0, '0, 0);
        write_reg(shll_pkg::RegSeedThreshold, 16'hFFFF);
        send_request(OpPixel, 17'd5000, 16'hFFFF, 0);
        send_request(OpEmit, '0, '0, 0);
    endtask

    task automatic test_random_phase(int count, logic [5:0] nb, logic [15:0] thr);
        write_reg(shll_pkg::RegNumBins, 16'(nb) | 16'($urandom_range(0, 1023)) << 6);
        write_reg(shll_pkg::RegSeedThreshold, thr);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_random(OpEmit, 17'($urandom), 16'($urandom));
            else if ($urandom_range(0, 15) == 0)
                send_random(OpPixel, 17'($urandom_range(65536, 131071)), 16'($urandom));
            else
                send_random(OpPixel, 17'($urandom_range(0, 65535)), 16'($urandom));
        end
        send_random(OpEmit, 17'($urandom), 16'($urandom));
    endtask

    task automatic test_pause_for_results();
        send_request(OpPixel, 17'd12345, 16'hFFFF, 0);
        send_request(OpEmit, '0, '0, 0);
        start <= 1'b0;
        while (pending_energies.size() != 0)
            @(posedge clk);
        send_request(OpPixel, 17'd54321, 16'hFFFF, 0);
        send_request(OpEmit, '0, '0, 0);
    endtask

    initial
    begin
        foreach (hist_counts[i])
            hist_counts[i] = '0;
        hist_total = '0;
        num_bins_reg = 6'd20;
        threshold_reg = 16'd6554;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_bin_extremes();
        test_random_phase(40, 6'd20, 16'($urandom_range(0, 20000)));
        test_random_phase(40, 6'd3, 16'($urandom_range(0, 65535)));
        test_pause_for_results();
        test_random_phase(40, 6'd32, 16'($urandom_range(0, 8000)));
        test_random_phase(30, 6'd1, 16'd100);
        test_random_phase(40, 6'($urandom_range(0, 63)), 16'($urandom));
        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/shll_pkg.sv
rtl/shll_front.sv
rtl/shll_queue.sv
rtl/shll_log2.sv
rtl/shll_back.sv
rtl/seeded_histogram_log_likelihood.sv
dv/seeded_histogram_log_likelihood_test.sv
